// File: rtl/core/smk_pkg.sv
`default_nettype none

package smk_pkg;

	localparam int FUNC_W   = 3;
	localparam int LEVEL_W  = 8;
	localparam int SUPPLY_W = 12;
	localparam int HITS_W   = 2;
	localparam int IVL_W    = 2;
	localparam int TONE_W   = 11;
	localparam int DRIVE_W  = 7;
	localparam int STEP_W   = 4;
	localparam int TICK_W   = 4;
	localparam int CFG_IDX_W = 1;

	// Event codes
	localparam logic [FUNC_W-1:0] FUNC_MEASURE   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_KEY_PRESS = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_KEY_REL   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_BUZZER    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_SIL_END   = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_QUIT_THR = 1'b1;

	localparam logic [LEVEL_W-1:0] FIRE_THR_RST = 8'd192;
	localparam logic [LEVEL_W-1:0] QUIT_THR_RST = 8'd86;
	localparam logic [LEVEL_W-1:0] THR_SILENCED = 8'hFF;

	localparam logic [IVL_W-1:0]  IVL_IDLE     = 2'd0;
	localparam logic [IVL_W-1:0]  IVL_FASTEST  = 2'd3;
	localparam logic [HITS_W-1:0] HITS_MAX     = 2'd3;
	localparam logic [HITS_W-1:0] HITS_TEST    = 2'd2;
	localparam logic [STEP_W-1:0] STEP_LAST    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_END     = 4'd8;
	localparam logic [TICK_W-1:0] TICKS_NORMAL = 4'd8;
	localparam logic [TICK_W-1:0] TICKS_SIL    = 4'd1;
	localparam logic [SUPPLY_W:0] SUPPLY_HYST  = 13'd8;

	typedef struct packed {
		logic [LEVEL_W-1:0]  smoke_level;
		logic                alarm_on;
		logic [HITS_W-1:0]   hit_count;
		logic [IVL_W-1:0]    interval_code;
		logic                interval_valid;
		logic                led_pulse;
		logic                buzzer_on;
		logic [TONE_W-1:0]   tone_period;
		logic                drive_update;
		logic [DRIVE_W-1:0]  drive_code;
		logic                sleep_allowed;
	} result_t;

	function automatic logic [TONE_W-1:0] tone_lookup(input logic [2:0] step);
		logic [TONE_W-1:0] t;
		case (step)
			3'd0:    t = 11'h495;
			3'd1:    t = 11'h490;
			3'd2:    t = 11'h480;
			3'd3:    t = 11'h460;
			3'd4:    t = 11'h430;
			3'd5:    t = 11'h3c0;
			3'd6:    t = 11'h320;
			default: t = 11'h250;
		endcase
		return t;
	endfunction

	// Returns {in_band, code}; in_band low at or below the lowest band.
	function automatic logic [DRIVE_W:0] band_lookup(input logic [SUPPLY_W-1:0] v);
		logic [DRIVE_W:0] r;
		if (v > 12'd2688)      r = {1'b1, 7'h08};
		else if (v > 12'd2474) r = {1'b1, 7'h09};
		else if (v > 12'd2389) r = {1'b1, 7'h48};
		else if (v > 12'd2304) r = {1'b1, 7'h49};
		else if (v > 12'd2218) r = {1'b1, 7'h0a};
		else if (v > 12'd2176) r = {1'b1, 7'h0b};
		else if (v > 12'd2133) r = {1'b1, 7'h4a};
		else if (v > 12'd2090) r = {1'b1, 7'h0c};
		else if (v > 12'd2048) r = {1'b1, 7'h4c};
		else if (v > 12'd2005) r = {1'b1, 7'h0e};
		else                   r = '0;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/smk_if.sv
`default_nettype none

interface smk_evt_if import smk_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [LEVEL_W-1:0]  lit_level;
	logic [LEVEL_W-1:0]  dark_level;
	logic [SUPPLY_W-1:0] supply_level;

	modport source (output valid, func, lit_level, dark_level, supply_level, input ready);
	modport sink (input valid, func, lit_level, dark_level, supply_level, output ready);
endinterface

interface smk_res_if import smk_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LEVEL_W-1:0]  smoke_level;
	logic                alarm_on;
	logic [HITS_W-1:0]   hit_count;
	logic [IVL_W-1:0]    interval_code;
	logic                interval_valid;
	logic                led_pulse;
	logic                buzzer_on;
	logic [TONE_W-1:0]   tone_period;
	logic                drive_update;
	logic [DRIVE_W-1:0]  drive_code;
	logic                sleep_allowed;

	modport source (output valid, smoke_level, alarm_on, hit_count, interval_code,
		interval_valid, led_pulse, buzzer_on, tone_period, drive_update, drive_code,
		sleep_allowed, input ready);
	modport sink (input valid, smoke_level, alarm_on, hit_count, interval_code,
		interval_valid, led_pulse, buzzer_on, tone_period, drive_update, drive_code,
		sleep_allowed, output ready);
endinterface

`default_nettype wire

// File: rtl/core/smoke_alarm_decision.sv
`default_nettype none
// An event transfer is captured in the event register, which feeds the decision
// logic; that logic loads the result register, from which the result is offered.
// Throughput: one event per cycle while results are taken; the event register and the result
// register form a two-stage pipe, so a new event is taken while a result waits.
// Reset (arst_n low, asynchronous): thresholds return to 192 / 86, alarm,
// hits, silence, self-test, buzzer and supply reference clear; sleep allowed.

module smoke_alarm_decision import smk_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	smk_evt_if.sink              evt,
	smk_res_if.source            res,
	input  wire                  wr_en,
	input  wire [CFG_IDX_W-1:0]  wr_index,
	input  wire [LEVEL_W-1:0]    wr_data
);

	// Configuration registers
	logic [LEVEL_W-1:0] fire_thr_q;
	logic [LEVEL_W-1:0] quit_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_thr_q <= FIRE_THR_RST;
			quit_thr_q <= QUIT_THR_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FIRE_THR: fire_thr_q <= wr_data;
				REG_QUIT_THR: quit_thr_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Event register (stage 1)
	logic                valid_s1;
	logic [FUNC_W-1:0]   func_s1;
	logic [LEVEL_W-1:0]  lit_s1;
	logic [LEVEL_W-1:0]  dark_s1;
	logic [SUPPLY_W-1:0] supply_s1;

	// Result register (stage 2)
	logic    valid_s2;
	result_t result_s2;

	// Stage 1 moves into stage 2 when the result slot is free or being drained.
	logic advance;
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			func_s1   <= evt.func;
			lit_s1    <= evt.lit_level;
			dark_s1   <= evt.dark_level;
			supply_s1 <= evt.supply_level;
		end
	end

	// Decision state, updated as each event leaves stage 1
	logic                alarm_q;
	logic [HITS_W-1:0]   hits_q;
	logic [LEVEL_W-1:0]  thr_now_q;
	logic                silenced_q;
	logic                self_test_q;
	logic [TICK_W-1:0]   led_ticks_q;
	logic [STEP_W-1:0]   tone_step_q;
	logic                buzz_q;
	logic [SUPPLY_W-1:0] supply_ref_q;
	logic                sleep_ok_q;
	logic                key_down_q;

	logic                alarm_d;
	logic [HITS_W-1:0]   hits_d;
	logic [LEVEL_W-1:0]  thr_now_d;
	logic                silenced_d;
	logic                self_test_d;
	logic [TICK_W-1:0]   led_ticks_d;
	logic [STEP_W-1:0]   tone_step_d;
	logic                buzz_d;
	logic [SUPPLY_W-1:0] supply_ref_d;
	logic                sleep_ok_d;
	logic                key_down_d;

	logic [LEVEL_W-1:0]  smoke;
	logic                adjust;
	logic [DRIVE_W:0]    band;
	logic [TICK_W-1:0]   ticks_inc;
	logic [STEP_W-1:0]   step_cap;
	logic [SUPPLY_W:0]   ref_hi;
	logic [SUPPLY_W:0]   ref_lo;
	result_t             res_d;

	always_comb begin
		alarm_d      = alarm_q;
		hits_d       = hits_q;
		thr_now_d    = thr_now_q;
		silenced_d   = silenced_q;
		self_test_d  = self_test_q;
		led_ticks_d  = led_ticks_q;
		tone_step_d  = tone_step_q;
		buzz_d       = buzz_q;
		supply_ref_d = supply_ref_q;
		sleep_ok_d   = sleep_ok_q;
		key_down_d   = key_down_q;
		res_d        = '0;

		smoke     = (lit_s1 >= dark_s1) ? (lit_s1 - dark_s1) : '0;
		// Supply moved by the hysteresis step either way, or no reference yet
		ref_hi    = {1'b0, supply_ref_q} + SUPPLY_HYST;
		ref_lo    = {1'b0, supply_ref_q} - SUPPLY_HYST;
		adjust    = (supply_ref_q == '0)
			|| ({1'b0, supply_s1} >= ref_hi)
			|| (({1'b0, supply_ref_q} >= SUPPLY_HYST) && ({1'b0, supply_s1} <= ref_lo));
		band      = band_lookup(supply_s1);
		ticks_inc = led_ticks_q + 1'b1;
		step_cap  = (tone_step_q >= STEP_END) ? STEP_LAST : tone_step_q;

		case (func_s1)
			FUNC_MEASURE: begin
				res_d.smoke_level    = smoke;
				res_d.interval_valid = 1'b1;
				if (adjust) begin
					supply_ref_d       = supply_s1;
					res_d.drive_update = band[DRIVE_W];
					res_d.drive_code   = band[DRIVE_W] ? band[DRIVE_W-1:0] : '0;
				end
				if (!silenced_q || self_test_q) begin
					if (smoke > thr_now_q) begin
						// Hit: count up and shorten the wake interval
						hits_d = (hits_q < HITS_MAX) ? hits_q + 1'b1 : hits_q;
						res_d.interval_code = hits_d;
						if (hits_d == HITS_MAX) begin
							alarm_d = 1'b1;
						end
						res_d.led_pulse = 1'b1;
						if (!self_test_q) begin
							thr_now_d = quit_thr_q;
						end
					end else begin
						// Clear air: drop back to idle and stop the buzzer
						hits_d      = '0;
						thr_now_d   = fire_thr_q;
						alarm_d     = 1'b0;
						buzz_d      = 1'b0;
						sleep_ok_d  = 1'b1;
						tone_step_d = '0;
					end
				end
				// Periodic indicator flash, faster while silenced
				led_ticks_d = ticks_inc;
				if (ticks_inc >= (silenced_q ? TICKS_SIL : TICKS_NORMAL)) begin
					res_d.led_pulse = 1'b1;
					led_ticks_d     = '0;
				end
			end
			FUNC_KEY_PRESS: begin
				if (!key_down_q) begin
					key_down_d           = 1'b1;
					res_d.interval_valid = 1'b1;
					if (alarm_q) begin
						silenced_d = 1'b1;
						thr_now_d  = THR_SILENCED;
						hits_d     = '0;
						alarm_d    = 1'b0;
						buzz_d     = 1'b0;
						sleep_ok_d = 1'b1;
					end else begin
						// Self-test: zero threshold, one hit short of alarm
						self_test_d         = 1'b1;
						thr_now_d           = '0;
						hits_d              = HITS_TEST;
						res_d.interval_code = IVL_FASTEST;
					end
				end
			end
			FUNC_KEY_REL: begin
				if (key_down_q) begin
					key_down_d  = 1'b0;
					alarm_d     = 1'b0;
					buzz_d      = 1'b0;
					sleep_ok_d  = 1'b1;
					tone_step_d = '0;
					if (!silenced_q) begin
						thr_now_d = fire_thr_q;
					end
					hits_d               = '0;
					self_test_d          = 1'b0;
					res_d.interval_valid = 1'b1;
					res_d.interval_code  = IVL_IDLE;
				end
			end
			FUNC_BUZZER: begin
				if (alarm_q) begin
					res_d.led_pulse = 1'b1;
					if (buzz_q) begin
						buzz_d     = 1'b0;
						sleep_ok_d = 1'b1;
					end else begin
						// Start the tone, stepping down the table and holding at its end
						res_d.tone_period = tone_lookup(step_cap[2:0]);
						buzz_d            = 1'b1;
						tone_step_d       = step_cap + 1'b1;
						sleep_ok_d        = 1'b0;
					end
				end
			end
			FUNC_SIL_END: begin
				if (silenced_q) begin
					silenced_d = 1'b0;
					thr_now_d  = fire_thr_q;
				end
			end
			default: ;
		endcase

		res_d.alarm_on      = alarm_d;
		res_d.hit_count     = hits_d;
		res_d.buzzer_on     = buzz_d;
		res_d.sleep_allowed = sleep_ok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q      <= 1'b0;
			hits_q       <= '0;
			thr_now_q    <= FIRE_THR_RST;
			silenced_q   <= 1'b0;
			self_test_q  <= 1'b0;
			led_ticks_q  <= '0;
			tone_step_q  <= '0;
			buzz_q       <= 1'b0;
			supply_ref_q <= '0;
			sleep_ok_q   <= 1'b1;
			key_down_q   <= 1'b0;
		end else if (advance) begin
			alarm_q      <= alarm_d;
			hits_q       <= hits_d;
			thr_now_q    <= thr_now_d;
			silenced_q   <= silenced_d;
			self_test_q  <= self_test_d;
			led_ticks_q  <= led_ticks_d;
			tone_step_q  <= tone_step_d;
			buzz_q       <= buzz_d;
			supply_ref_q <= supply_ref_d;
			sleep_ok_q   <= sleep_ok_d;
			key_down_q   <= key_down_d;
		end
	end

	// Result register: hold until transfer, load on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_d;
		end
	end

	assign res.valid          = valid_s2;
	assign res.smoke_level    = result_s2.smoke_level;
	assign res.alarm_on       = result_s2.alarm_on;
	assign res.hit_count      = result_s2.hit_count;
	assign res.interval_code  = result_s2.interval_code;
	assign res.interval_valid = result_s2.interval_valid;
	assign res.led_pulse      = result_s2.led_pulse;
	assign res.buzzer_on      = result_s2.buzzer_on;
	assign res.tone_period    = result_s2.tone_period;
	assign res.drive_update   = result_s2.drive_update;
	assign res.drive_code     = result_s2.drive_code;
	assign res.sleep_allowed  = result_s2.sleep_allowed;

endmodule

`default_nettype wire

// File: tb/smk_decision_checker.sv
`timescale 1ns / 1ps

module smk_decision_checker import smk_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	smk_evt_if                  evt,
	smk_res_if                  res,
	input  wire                 wr_en,
	input  wire [CFG_IDX_W-1:0] wr_index,
	input  wire [LEVEL_W-1:0]   wr_data,
	output int                  failures,
	output int                  pending,
	output int                  compared,
	output int                  alarm_results
);

	logic [LEVEL_W-1:0]  fire_thr;
	logic [LEVEL_W-1:0]  quit_thr;
	logic [LEVEL_W-1:0]  thr_now;
	logic                alarm_active;
	logic                silenced;
	logic                self_test;
	logic                buzzer_running;
	logic                sleep_ok;
	logic                key_down;
	logic [HITS_W-1:0]   hits;
	logic [TICK_W-1:0]   led_ticks;
	logic [STEP_W-1:0]   tone_step;
	logic [SUPPLY_W-1:0] supply_ref;

	result_t expected_decisions[$];
	int      mismatches;
	int      checked;
	int      alarm_count;

	function automatic string show_decision(input result_t r);
		return $sformatf({"smoke=%0d alarm=%0b hits=%0d ivl=%0d/%0b led=%0b buz=%0b ",
			"tone=%h drive=%0b/%h sleep=%0b"}, r.smoke_level, r.alarm_on, r.hit_count,
			r.interval_code, r.interval_valid, r.led_pulse, r.buzzer_on, r.tone_period,
			r.drive_update, r.drive_code, r.sleep_allowed);
	endfunction

	// Advance the alarm state by one event and return the decision it produces.
	function automatic result_t decide_event(input logic [FUNC_W-1:0] func,
		input logic [LEVEL_W-1:0] lit, input logic [LEVEL_W-1:0] dark,
		input logic [SUPPLY_W-1:0] supply);
		result_t r;
		logic    rebase;
		r = '0;
		case (func)
			FUNC_MEASURE: begin
				r.smoke_level = (lit >= dark) ? lit - dark : '0;
				// full-range distance test, no wraparound
				rebase = (supply_ref == '0)
					|| ({1'b0, supply} >= {1'b0, supply_ref} + SUPPLY_HYST)
					|| ({1'b0, supply} + SUPPLY_HYST <= {1'b0, supply_ref});
				if (rebase) begin
					supply_ref = supply;
					r.drive_update = 1'b1;
					if (supply > 12'd2688)      r.drive_code = 7'h08;
					else if (supply > 12'd2474) r.drive_code = 7'h09;
					else if (supply > 12'd2389) r.drive_code = 7'h48;
					else if (supply > 12'd2304) r.drive_code = 7'h49;
					else if (supply > 12'd2218) r.drive_code = 7'h0a;
					else if (supply > 12'd2176) r.drive_code = 7'h0b;
					else if (supply > 12'd2133) r.drive_code = 7'h4a;
					else if (supply > 12'd2090) r.drive_code = 7'h0c;
					else if (supply > 12'd2048) r.drive_code = 7'h4c;
					else if (supply > 12'd2005) r.drive_code = 7'h0e;
					else r.drive_update = 1'b0;
				end
				r.interval_valid = 1'b1;
				if (!silenced || self_test) begin
					if (r.smoke_level > thr_now) begin
						if (hits != HITS_MAX) hits = hits + 1'b1;
						r.interval_code = hits;
						if (hits == HITS_MAX) alarm_active = 1'b1;
						r.led_pulse = 1'b1;
						if (!self_test) thr_now = quit_thr;
					end else begin
						hits = '0;
						thr_now = fire_thr;
						alarm_active = 1'b0;
						buzzer_running = 1'b0;
						sleep_ok = 1'b1;
						tone_step = '0;
					end
				end
				led_ticks = led_ticks + 1'b1;
				if (led_ticks >= (silenced ? TICKS_SIL : TICKS_NORMAL)) begin
					r.led_pulse = 1'b1;
					led_ticks = '0;
				end
			end
			FUNC_KEY_PRESS: begin
				if (!key_down) begin
					key_down = 1'b1;
					r.interval_valid = 1'b1;
					if (alarm_active) begin
						silenced = 1'b1;
						thr_now = THR_SILENCED;
						hits = '0;
						alarm_active = 1'b0;
						buzzer_running = 1'b0;
						sleep_ok = 1'b1;
						r.interval_code = IVL_IDLE;
					end else begin
						self_test = 1'b1;
						thr_now = '0;
						hits = HITS_TEST;
						r.interval_code = IVL_FASTEST;
					end
				end
			end
			FUNC_KEY_REL: begin
				if (key_down) begin
					key_down = 1'b0;
					alarm_active = 1'b0;
					buzzer_running = 1'b0;
					sleep_ok = 1'b1;
					tone_step = '0;
					if (!silenced) thr_now = fire_thr;
					hits = '0;
					self_test = 1'b0;
					r.interval_valid = 1'b1;
					r.interval_code = IVL_IDLE;
				end
			end
			FUNC_BUZZER: begin
				if (alarm_active) begin
					r.led_pulse = 1'b1;
					if (buzzer_running) begin
						buzzer_running = 1'b0;
						sleep_ok = 1'b1;
					end else begin
						if (tone_step >= STEP_END) tone_step = STEP_LAST;
						case (tone_step[2:0])
							3'd0:    r.tone_period = 11'h495;
							3'd1:    r.tone_period = 11'h490;
							3'd2:    r.tone_period = 11'h480;
							3'd3:    r.tone_period = 11'h460;
							3'd4:    r.tone_period = 11'h430;
							3'd5:    r.tone_period = 11'h3c0;
							3'd6:    r.tone_period = 11'h320;
							default: r.tone_period = 11'h250;
						endcase
						buzzer_running = 1'b1;
						tone_step = tone_step + 1'b1;
						sleep_ok = 1'b0;
					end
				end
			end
			FUNC_SIL_END: begin
				if (silenced) begin
					silenced = 1'b0;
					thr_now = fire_thr;
				end
			end
			default: ;
		endcase
		r.alarm_on = alarm_active;
		r.hit_count = hits;
		r.buzzer_on = buzzer_running;
		r.sleep_allowed = sleep_ok;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t got;
		result_t want;
		string   wrong;
		if (!arst_n) begin
			fire_thr = FIRE_THR_RST;
			quit_thr = QUIT_THR_RST;
			thr_now = FIRE_THR_RST;
			alarm_active = 1'b0;
			silenced = 1'b0;
			self_test = 1'b0;
			buzzer_running = 1'b0;
			sleep_ok = 1'b1;
			key_down = 1'b0;
			hits = '0;
			led_ticks = '0;
			tone_step = '0;
			supply_ref = '0;
			expected_decisions.delete();
			mismatches = 0;
			checked = 0;
			alarm_count = 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_FIRE_THR) fire_thr = wr_data;
				else quit_thr = wr_data;
			end
			// results always trail their event: pop before push
			if (res.valid && res.ready) begin
				got.smoke_level = res.smoke_level;
				got.alarm_on = res.alarm_on;
				got.hit_count = res.hit_count;
				got.interval_code = res.interval_code;
				got.interval_valid = res.interval_valid;
				got.led_pulse = res.led_pulse;
				got.buzzer_on = res.buzzer_on;
				got.tone_period = res.tone_period;
				got.drive_update = res.drive_update;
				got.drive_code = res.drive_code;
				got.sleep_allowed = res.sleep_allowed;
				if (expected_decisions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] result with nothing expected: %s", $time,
							show_decision(got));
				end else begin
					want = expected_decisions.pop_front();
					wrong = "";
					if (got.smoke_level !== want.smoke_level) wrong = {wrong, " smoke_level"};
					if (got.alarm_on !== want.alarm_on) wrong = {wrong, " alarm_on"};
					if (got.hit_count !== want.hit_count) wrong = {wrong, " hit_count"};
					if (got.interval_code !== want.interval_code)
						wrong = {wrong, " interval_code"};
					if (got.interval_valid !== want.interval_valid)
						wrong = {wrong, " interval_valid"};
					if (got.led_pulse !== want.led_pulse) wrong = {wrong, " led_pulse"};
					if (got.buzzer_on !== want.buzzer_on) wrong = {wrong, " buzzer_on"};
					if (got.tone_period !== want.tone_period) wrong = {wrong, " tone_period"};
					if (got.drive_update !== want.drive_update) wrong = {wrong, " drive_update"};
					if (got.drive_code !== want.drive_code) wrong = {wrong, " drive_code"};
					if (got.sleep_allowed !== want.sleep_allowed)
						wrong = {wrong, " sleep_allowed"};
					checked++;
					if (want.alarm_on) alarm_count++;
					if (wrong != "") begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0t] mismatch in%s\n  expected %s\n  actual   %s", $time,
								wrong, show_decision(want), show_decision(got));
					end
				end
			end
			if (evt.valid && evt.ready)
				expected_decisions.push_back(decide_event(evt.func, evt.lit_level,
					evt.dark_level, evt.supply_level));
		end
		failures <= mismatches;
		pending <= expected_decisions.size();
		compared <= checked;
		alarm_results <= alarm_count;
	end

endmodule

// File: tb/tb_smoke_alarm_decision.sv
`timescale 1ns / 1ps

module tb_smoke_alarm_decision;
	import smk_pkg::*;

	localparam int PHASES           = 6;
	localparam int EVENTS_PER_PHASE = 250;
	// long enough for the two-stage pipe to fill and push back on the event side
	localparam int RESULT_HOLD      = 80;
	// settle margin after a drain
	localparam int SETTLE_CYCLES    = 4;

	localparam int BAND_EDGES [10] = '{2005, 2048, 2090, 2133, 2176, 2218, 2304, 2389,
		2474, 2688};

	typedef enum int {SMOKE_ANY, SMOKE_FIRE, SMOKE_MID, SMOKE_CLEAR} smoke_kind_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = REG_FIRE_THR;
	logic [LEVEL_W-1:0]   wr_data = '0;

	int failures;
	int pending;
	int compared;
	int alarm_results;

	// stimulus bookkeeping
	int                  fire_set = FIRE_THR_RST;
	int                  quit_set = QUIT_THR_RST;
	logic [SUPPLY_W-1:0] rail = 12'd2400;
	bit                  sender_idle = 1'b1;
	int                  phase_events;
	int                  n_measure;
	int                  n_key;
	int                  n_buzzer;
	int                  n_other;
	int                  hold_requests;
	int                  holds_done;

	smk_evt_if evt_ch ();
	smk_res_if res_ch ();

	smoke_alarm_decision i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt_ch),
		.res      (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	smk_decision_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt           (evt_ch),
		.res           (res_ch),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.failures      (failures),
		.pending       (pending),
		.compared      (compared),
		.alarm_results (alarm_results)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 40));
	endfunction

	function automatic logic [LEVEL_W-1:0] any_level();
		return LEVEL_W'($urandom);
	endfunction

	// Walk the supply reading: small drifts around the current rail so the
	// hysteresis window gets hit from both sides, band edges, the full range,
	// and the zero reading that drops the reference.
	function automatic logic [SUPPLY_W-1:0] next_supply();
		int pick;
		int v;
		pick = $urandom_range(0, 99);
		if (pick < 60) v = int'(rail) + int'($urandom_range(0, 24)) - 12;
		else if (pick < 78) v = BAND_EDGES[$urandom_range(0, 9)] + int'($urandom_range(0, 4)) - 2;
		else if (pick < 92) v = int'($urandom_range(0, 4095));
		else if (pick < 95) v = 0;
		else if (pick < 98) v = 4095 - int'($urandom_range(0, 3));
		else v = int'($urandom_range(0, 15));
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		rail = SUPPLY_W'(v);
		return rail;
	endfunction

	// Offer one event and hold it until the transfer; then maybe idle a while.
	task automatic send(input logic [FUNC_W-1:0] func, input logic [LEVEL_W-1:0] lit,
		input logic [LEVEL_W-1:0] dark, input logic [SUPPLY_W-1:0] supply);
		int idle;
		evt_ch.valid <= 1'b1;
		evt_ch.func <= func;
		evt_ch.lit_level <= lit;
		evt_ch.dark_level <= dark;
		evt_ch.supply_level <= supply;
		do @(posedge clk); while (!evt_ch.ready);
		case (func)
			FUNC_MEASURE:                n_measure++;
			FUNC_KEY_PRESS, FUNC_KEY_REL: n_key++;
			FUNC_BUZZER:                 n_buzzer++;
			default:                     n_other++;
		endcase
		if (func <= FUNC_SIL_END) phase_events++;
		idle = (sender_idle && $urandom_range(0, 1) != 0) ? gap_length() : 0;
		if (idle > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
	endtask

	// Non-measure events still carry random payload; the block must ignore it.
	task automatic plain_event(input logic [FUNC_W-1:0] func);
		send(func, any_level(), any_level(), SUPPLY_W'($urandom));
	endtask

	// Measurement with a net level picked relative to the programmed thresholds.
	task automatic measure(input smoke_kind_e kind);
		int lo;
		int hi;
		int level;
		int dark;
		case (kind)
			SMOKE_FIRE: begin
				lo = (fire_set == 255) ? 255 : fire_set + 1;
				hi = 255;
			end
			SMOKE_MID: begin
				lo = (quit_set == 255) ? 255 : quit_set + 1;
				hi = fire_set;
			end
			SMOKE_CLEAR: begin
				lo = 0;
				hi = quit_set;
			end
			default: begin
				send(FUNC_MEASURE, any_level(), any_level(), next_supply());
				return;
			end
		endcase
		level = int'($urandom_range(lo, hi));
		dark = int'($urandom_range(0, 255 - level));
		// a clear reading may also come with dark above lit, clamped to zero
		if (kind == SMOKE_CLEAR && $urandom_range(0, 3) == 0)
			send(FUNC_MEASURE, LEVEL_W'(dark), LEVEL_W'(dark + level), next_supply());
		else
			send(FUNC_MEASURE, LEVEL_W'(dark + level), LEVEL_W'(dark), next_supply());
	endtask

	// Drop valid and hold off until every decision has come back.
	task automatic drain();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic program_thresholds(input int fire, input int quit);
		wr_en <= 1'b1;
		wr_index <= REG_FIRE_THR;
		wr_data <= LEVEL_W'(fire);
		@(posedge clk);
		wr_index <= REG_QUIT_THR;
		wr_data <= LEVEL_W'(quit);
		@(posedge clk);
		wr_en <= 1'b0;
		fire_set = fire;
		quit_set = quit;
	endtask

	// One random sequence. About half of them are alarm episodes so the buzzer,
	// silence and self-test paths see real traffic; the rest is quiet
	// measuring, out-of-order key events and plain noise.
	task automatic random_episode();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				repeat ($urandom_range(2, 5)) measure(SMOKE_FIRE);
				if ($urandom_range(0, 2) == 0) measure(SMOKE_MID);
				// long bursts run the tone step off the end of the table
				repeat ($urandom_range(0, 20)) begin
					if ($urandom_range(0, 5) == 0) measure(SMOKE_FIRE);
					else plain_event(FUNC_BUZZER);
				end
				case ($urandom_range(0, 3))
					0: begin
						plain_event(FUNC_KEY_PRESS);
						repeat ($urandom_range(1, 4)) measure(smoke_kind_e'($urandom_range(0, 3)));
						if ($urandom_range(0, 1) != 0) plain_event(FUNC_BUZZER);
						plain_event(FUNC_SIL_END);
						plain_event(FUNC_KEY_REL);
					end
					1: begin
						plain_event(FUNC_KEY_PRESS);
						plain_event(FUNC_KEY_REL);
						measure(smoke_kind_e'($urandom_range(0, 3)));
						plain_event(FUNC_SIL_END);
					end
					2: measure(SMOKE_CLEAR);
					default: ;
				endcase
			end
			4: begin
				plain_event(FUNC_KEY_PRESS);
				repeat ($urandom_range(1, 3)) measure(smoke_kind_e'($urandom_range(0, 3)));
				repeat ($urandom_range(0, 4)) plain_event(FUNC_BUZZER);
				plain_event(FUNC_KEY_REL);
			end
			5, 6: repeat ($urandom_range(2, 8)) measure(smoke_kind_e'($urandom_range(0, 3)));
			7: begin
				case ($urandom_range(0, 4))
					0: plain_event(FUNC_KEY_REL);
					1: begin
						plain_event(FUNC_KEY_PRESS);
						plain_event(FUNC_KEY_PRESS);
						plain_event(FUNC_KEY_REL);
					end
					2: plain_event(FUNC_SIL_END);
					3: plain_event(FUNC_BUZZER);
					default: plain_event(FUNC_W'($urandom_range(5, 7)));
				endcase
			end
			8: repeat ($urandom_range(1, 5))
				send(FUNC_W'($urandom), any_level(), any_level(), SUPPLY_W'($urandom));
			default: begin
				// silence the alarm, then start a self-test while still silenced
				repeat (3) measure(SMOKE_FIRE);
				plain_event(FUNC_KEY_PRESS);
				plain_event(FUNC_KEY_REL);
				plain_event(FUNC_KEY_PRESS);
				repeat (2) measure(smoke_kind_e'($urandom_range(0, 3)));
				plain_event(FUNC_KEY_REL);
				plain_event(FUNC_SIL_END);
			end
		endcase
		if ($urandom_range(0, 49) == 0) drain();
	endtask

	// Result side: ready runs of random length, short and long gaps, and a
	// long hold-off whenever the stimulus asks for one.
	initial begin : result_sink
		res_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (holds_done != hold_requests) begin
				holds_done++;
				res_ch.ready <= 1'b0;
				repeat (RESULT_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 3) != 0) begin
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b0;
				repeat (gap_length()) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int phase;
		evt_ch.valid = 1'b0;
		evt_ch.func = FUNC_MEASURE;
		evt_ch.lit_level = '0;
		evt_ch.dark_level = '0;
		evt_ch.supply_level = '0;
		hold_requests = 0;
		holds_done = 0;
		n_measure = 0;
		n_key = 0;
		n_buzzer = 0;
		n_other = 0;
		phase_events = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening under the reset thresholds (fire 192, quit 86).
		// Full reading with a zero supply: a hit, and the reference stays empty.
		send(FUNC_MEASURE, 8'd255, 8'd0, 12'd0);
		// Dark above lit clamps to zero; first real supply sets the top band.
		send(FUNC_MEASURE, 8'd0, 8'd255, 12'd4095);
		// Supply moved by seven: no new drive code.
		send(FUNC_MEASURE, 8'd255, 8'd0, 12'd4088);
		// Moved by eight: drive code again.
		send(FUNC_MEASURE, 8'd255, 8'd0, 12'd4087);
		// Third hit in a row raises the alarm; supply at the lowest band edge sends no code.
		send(FUNC_MEASURE, 8'd255, 8'd0, 12'd2005);
		// Hit count saturates.
		send(FUNC_MEASURE, 8'd255, 8'd0, 12'd2005);
		plain_event(FUNC_BUZZER);
		plain_event(FUNC_BUZZER);
		plain_event(FUNC_BUZZER);
		// Key press during the alarm silences it; a repeated press is ignored.
		plain_event(FUNC_KEY_PRESS);
		plain_event(FUNC_KEY_PRESS);
		// Silenced without self-test: no hit is counted; the drive code still updates.
		send(FUNC_MEASURE, 8'd255, 8'd0, 12'd2013);
		plain_event(FUNC_KEY_REL);
		plain_event(FUNC_SIL_END);
		// Silence expiry when not silenced, release without press, buzzer without alarm.
		plain_event(FUNC_SIL_END);
		plain_event(FUNC_KEY_REL);
		plain_event(FUNC_BUZZER);
		// Self-test: threshold drops to zero, so the smallest level is a hit.
		plain_event(FUNC_KEY_PRESS);
		send(FUNC_MEASURE, 8'd1, 8'd0, 12'd2689);
		plain_event(FUNC_KEY_REL);
		// Unused codes.
		send(3'd5, 8'd255, 8'd255, 12'd4095);
		send(3'd7, 8'd0, 8'd0, 12'd0);
		// Supply falls to zero, then a small reading starts a reference again.
		send(FUNC_MEASURE, 8'd128, 8'd128, 12'd0);
		send(FUNC_MEASURE, 8'd127, 8'd128, 12'd8);

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain();
				repeat (SETTLE_CYCLES) @(posedge clk);
				case (phase)
					1: program_thresholds(0, 0);
					2: program_thresholds(255, 255);
					3: program_thresholds(255, 0);
					4: program_thresholds(0, 255);
					default: program_thresholds(int'($urandom_range(100, 220)),
						int'($urandom_range(30, 150)));
				endcase
			end
			// one phase runs back to back with no sender idling
			sender_idle = (phase != 1);
			hold_requests++;
			phase_events = 0;
			while (phase_events < EVENTS_PER_PHASE) random_episode();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d measurements, %0d key, %0d buzzer and %0d other events",
			n_measure, n_key, n_buzzer, n_other);
		$display("over %0d threshold settings; %0d decisions compared, %0d with alarm raised.",
			PHASES, compared, alarm_results);
		if (failures == 0 && pending == 0) begin
			$display("smoke_alarm_decision verification clean");
		end else begin
			$display("smoke_alarm_decision verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#10_000_000;
		$display("smoke_alarm_decision verification failed");
		$finish;
	end

endmodule
